[sv/r16x_pkg.sv]
package r16x_pkg;

   localparam int WORD_BITS = 16;

   localparam logic [4:0] OP_ADD = 5'd0;
   localparam logic [4:0] OP_SUB = 5'd1;
   localparam logic [4:0] OP_MUL = 5'd2;
   localparam logic [4:0] OP_DIV = 5'd3;
   localparam logic [4:0] OP_AND = 5'd4;
   localparam logic [4:0] OP_OR  = 5'd5;
   localparam logic [4:0] OP_XOR = 5'd6;
   localparam logic [4:0] OP_SHL = 5'd7;
   localparam logic [4:0] OP_STB = 5'd8;
   localparam logic [4:0] OP_STW = 5'd9;
   localparam logic [4:0] OP_LDB = 5'd10;
   localparam logic [4:0] OP_LDW = 5'd11;
   localparam logic [4:0] OP_JMP = 5'd12;
   localparam logic [4:0] OP_JZS = 5'd13;
   localparam logic [4:0] OP_JZC = 5'd14;
   localparam logic [4:0] OP_JCS = 5'd15;
   localparam logic [4:0] OP_JCC = 5'd16;
   localparam logic [4:0] OP_JNS = 5'd17;
   localparam logic [4:0] OP_JNC = 5'd18;
   localparam logic [4:0] OP_IN  = 5'd19;
   localparam logic [4:0] OP_OUT = 5'd20;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_OVF  = 2'd1;
   localparam logic [1:0] STAT_DIVZ = 2'd2;
   localparam logic [1:0] STAT_ADDR = 2'd3;

   localparam logic [1:0] SEL_SRC    = 2'd0;
   localparam logic [1:0] SEL_SECOND = 2'd1;
   localparam logic [1:0] SEL_DEST   = 2'd2;

   typedef struct packed {
      logic       load;
      logic [1:0] rf_sel;
      logic       cap_a;
      logic       cap_b;
      logic       cap_d;
      logic       div_start;
      logic       div_step;
      logic       mem_we;
      logic       mem_hi;
      logic       cap_lo;
      logic       cap_hi;
      logic       clr_we;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic [4:0] action;
      logic       div_zero;
      logic       div_done;
      logic       addr_bad;
      logic       clr_last;
      logic       out_free;
   } sts_type;

endpackage

[sv/r16x_ram.sv]
module r16x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/r16x_ctrl.sv]
module r16x_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  r16x_pkg::sts_type sts,
   output r16x_pkg::cmd_type cmd
);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RA   = 4'd2;
   localparam logic [3:0] S_RB   = 4'd3;
   localparam logic [3:0] S_RD   = 4'd4;
   localparam logic [3:0] S_RX   = 4'd5;
   localparam logic [3:0] S_DEC  = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_M1   = 4'd8;
   localparam logic [3:0] S_M2   = 4'd9;
   localparam logic [3:0] S_WB   = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLR: begin
            cmd.clr_we = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_RA;
            end
         end
         S_RA: begin
            cmd.rf_sel = r16x_pkg::SEL_SRC;
            state_in   = S_RB;
         end
         S_RB: begin
            cmd.cap_a  = 1'b1;
            cmd.rf_sel = r16x_pkg::SEL_SECOND;
            state_in   = S_RD;
         end
         S_RD: begin
            cmd.cap_b  = 1'b1;
            cmd.rf_sel = r16x_pkg::SEL_DEST;
            state_in   = S_RX;
         end
         S_RX: begin
            cmd.cap_d = 1'b1;
            state_in  = S_DEC;
         end
         S_DEC: begin
            state_in = S_WB;
            if (sts.action == r16x_pkg::OP_DIV) begin
               if (!sts.div_zero) begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else if (sts.action inside {r16x_pkg::OP_STB, r16x_pkg::OP_STW}) begin
               if (!sts.addr_bad) begin
                  cmd.mem_we = 1'b1;
                  if (sts.action == r16x_pkg::OP_STW) state_in = S_M1;
               end
            end else if (sts.action inside {r16x_pkg::OP_LDB, r16x_pkg::OP_LDW}) begin
               if (!sts.addr_bad) state_in = S_M1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_WB;
         end
         S_M1: begin
            cmd.mem_hi = 1'b1;
            state_in   = S_WB;
            if (sts.action == r16x_pkg::OP_STW) begin
               cmd.mem_we = 1'b1;
            end else begin
               cmd.cap_lo = 1'b1;
               if (sts.action == r16x_pkg::OP_LDW) state_in = S_M2;
            end
         end
         S_M2: begin
            cmd.cap_hi = 1'b1;
            state_in   = S_WB;
         end
         S_WB: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

[sv/r16x_dpath.sv]
module r16x_dpath #(
   parameter int MEM_BYTES = 65536,
   parameter int REG_COUNT = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  r16x_pkg::cmd_type cmd,
   output r16x_pkg::sts_type sts,
   input  logic [55:0]       req_tdata,
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam int IW = $clog2(REG_COUNT);
   localparam int WB = r16x_pkg::WORD_BITS;
   localparam logic signed [17:0] LAST_ADDR = 18'(MEM_BYTES - 1);

   logic [4:0]          act_ff, dst_ff, src_ff, sec_ff;
   logic                use_imm_ff;
   logic [WB-1:0]       imm_ff, inv_ff;
   logic signed [WB-1:0] a_ff, b_ff, d_ff;
   logic [7:0]          lo_ff, hi_ff;
   logic [16:0]         quo_ff, rem_ff, dvs_ff;
   logic                qneg_ff;
   logic [4:0]          dcnt_ff;
   logic [AW-1:0]       clr_ff;
   logic                z_ff, c_ff, n_ff;
   logic [REG_COUNT-1:0] vld_ff;
   logic                rsp_valid_ff;
   logic [37:0]         rsp_data_ff;

   logic [4:0]          sel_fld;
   logic [IW-1:0]       rf_raddr;
   logic [WB-1:0]       rf_rdata;
   logic                rf_we;
   logic [WB-1:0]       res;
   logic                wr;

   function automatic logic reg_ok(input logic [4:0] f, input logic [REG_COUNT-1:0] v);
      logic ok;
      ok = (f != 5'd0) && ({1'b0, f} < 6'(REG_COUNT));
      return ok && v[f[IW-1:0]];
   endfunction

   always_comb begin
      case (cmd.rf_sel)
         r16x_pkg::SEL_SECOND: sel_fld = sec_ff;
         r16x_pkg::SEL_DEST:   sel_fld = dst_ff;
         default:              sel_fld = src_ff;
      endcase
   end
   assign rf_raddr = sel_fld[IW-1:0];

   // address
   logic signed [17:0] ad;
   logic [AW-1:0]      ad_lo, ad_hi, mem_waddr, mem_raddr;
   logic [7:0]         mem_wdata, mem_rdata;
   logic               is_store, is_word;

   assign is_store = (act_ff == r16x_pkg::OP_STB) || (act_ff == r16x_pkg::OP_STW);
   assign is_word  = (act_ff == r16x_pkg::OP_STW) || (act_ff == r16x_pkg::OP_LDW);
   assign ad = (is_store ? 18'(d_ff) : 18'(a_ff)) + 18'(b_ff);
   assign ad_lo = ad[AW-1:0];
   assign ad_hi = ad_lo + AW'(1);
   assign mem_raddr = cmd.mem_hi ? ad_hi : ad_lo;
   assign mem_waddr = cmd.clr_we ? clr_ff : mem_raddr;
   assign mem_wdata = cmd.clr_we ? 8'd0 : (cmd.mem_hi ? a_ff[15:8] : a_ff[7:0]);

   r16x_ram #(.WIDTH(WB), .DEPTH(REG_COUNT)) u_rf (
      .clock(clock), .we(rf_we), .waddr(dst_ff[IW-1:0]), .wdata(res),
      .raddr(rf_raddr), .rdata(rf_rdata)
   );

   r16x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .we(cmd.clr_we | cmd.mem_we), .waddr(mem_waddr),
      .wdata(mem_wdata), .raddr(mem_raddr), .rdata(mem_rdata)
   );

   // divider
   logic [17:0] rem_sh, rem_dif;
   logic [16:0] a_mag, b_mag, q_fin;
   assign a_mag   = a_ff[15] ? 17'(-{a_ff[15], a_ff}) : {1'b0, a_ff};
   assign b_mag   = b_ff[15] ? 17'(-{b_ff[15], b_ff}) : {1'b0, b_ff};
   assign rem_sh  = {rem_ff, quo_ff[16]};
   assign rem_dif = rem_sh - {1'b0, dvs_ff};
   assign q_fin   = qneg_ff ? 17'(-quo_ff) : quo_ff;

   // execute
   logic [16:0] sum17, dif17, sh_l, sh_r;
   logic [4:0]  shn;
   logic [1:0]  stat;
   logic        taken, go, z_in, c_in, n_in, outok;
   logic [WB-1:0] outv, tv;
   logic [16:0] tadj;
   logic [7:0]  sbyte;
   logic signed [15:0] prod;

   assign sum17 = {a_ff[15], a_ff} + {b_ff[15], b_ff};
   assign dif17 = {a_ff[15], a_ff} - {b_ff[15], b_ff};
   assign prod  = $signed(a_ff[7:0]) * $signed(b_ff[7:0]);
   assign shn   = b_ff[15] ? 5'(-b_ff) : b_ff[4:0];
   assign sh_l  = {1'b0, a_ff} << shn;
   assign sh_r  = {a_ff, 1'b0} >> shn;
   assign tv    = use_imm_ff ? imm_ff : d_ff;
   assign tadj  = {tv[15], tv} + (tv[15] ? 17'd3 : 17'd0);

   always_comb begin
      stat  = r16x_pkg::STAT_OK;
      res   = '0;
      wr    = 1'b0;
      z_in  = z_ff;
      c_in  = c_ff;
      n_in  = n_ff;
      taken = 1'b0;
      go    = 1'b0;
      outok = 1'b0;
      outv  = '0;
      sbyte = '0;
      case (act_ff)
         r16x_pkg::OP_ADD: begin
            res = sum17[15:0];
            wr  = 1'b1;
            if (sum17[16] != sum17[15]) stat = r16x_pkg::STAT_OVF;
         end
         r16x_pkg::OP_SUB: begin
            res = dif17[15:0];
            wr  = 1'b1;
            if (dif17[16] != dif17[15]) stat = r16x_pkg::STAT_OVF;
         end
         r16x_pkg::OP_MUL: begin
            res = prod;
            wr  = 1'b1;
         end
         r16x_pkg::OP_DIV: begin
            if (b_ff == '0) begin
               stat = r16x_pkg::STAT_DIVZ;
            end else begin
               res = q_fin[15:0];
               wr  = 1'b1;
            end
         end
         r16x_pkg::OP_AND: begin res = a_ff & b_ff; wr = 1'b1; end
         r16x_pkg::OP_OR:  begin res = a_ff | b_ff; wr = 1'b1; end
         r16x_pkg::OP_XOR: begin res = a_ff ^ b_ff; wr = 1'b1; end
         r16x_pkg::OP_SHL: begin
            if (b_ff == '0) begin
               z_in = (d_ff == '0);
               n_in = d_ff[15];
            end else if (b_ff > 16 || b_ff < -16) begin
               c_in = 1'b0;
               wr   = 1'b1;
            end else if (!b_ff[15]) begin
               c_in = sh_l[16];
               res  = sh_l[15:0];
               wr   = 1'b1;
            end else begin
               c_in = sh_r[0];
               res  = sh_r[16:1];
               wr   = 1'b1;
            end
         end
         r16x_pkg::OP_STB, r16x_pkg::OP_STW: begin
            if (sts.addr_bad) begin
               stat = r16x_pkg::STAT_ADDR;
            end else begin
               sbyte = (act_ff == r16x_pkg::OP_STW) ? a_ff[15:8] : a_ff[7:0];
               z_in  = (sbyte == 8'd0);
               n_in  = sbyte[7];
            end
         end
         r16x_pkg::OP_LDB, r16x_pkg::OP_LDW: begin
            if (sts.addr_bad) begin
               stat = r16x_pkg::STAT_ADDR;
            end else begin
               res = (act_ff == r16x_pkg::OP_LDW) ? {hi_ff, lo_ff} : {{8{lo_ff[7]}}, lo_ff};
               wr  = 1'b1;
            end
         end
         r16x_pkg::OP_JMP: go = 1'b1;
         r16x_pkg::OP_JZS: go = z_ff;
         r16x_pkg::OP_JZC: go = !z_ff;
         r16x_pkg::OP_JCS: go = c_ff;
         r16x_pkg::OP_JCC: go = !c_ff;
         r16x_pkg::OP_JNS: go = n_ff;
         r16x_pkg::OP_JNC: go = !n_ff;
         r16x_pkg::OP_IN: begin res = inv_ff; wr = 1'b1; end
         r16x_pkg::OP_OUT: begin outv = d_ff; outok = 1'b1; end
         default: ;
      endcase
      taken = go;
      if (wr) begin
         z_in = (res == '0);
         n_in = res[15];
      end
   end

   assign rf_we = cmd.commit && wr && (dst_ff != 5'd0) && ({1'b0, dst_ff} < 6'(REG_COUNT));

   assign sts.action   = act_ff;
   assign sts.div_zero = (b_ff == '0);
   assign sts.div_done = (dcnt_ff == 5'd16);
   assign sts.addr_bad = (ad < 0) || (ad > LAST_ADDR) || (is_word && ad == LAST_ADDR);
   assign sts.clr_last = (clr_ff == AW'(MEM_BYTES - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff     <= req_tdata[4:0];
         dst_ff     <= req_tdata[9:5];
         src_ff     <= req_tdata[14:10];
         sec_ff     <= req_tdata[19:15];
         imm_ff     <= req_tdata[35:20];
         inv_ff     <= req_tdata[51:36];
         use_imm_ff <= req_tuser;
      end
      if (cmd.cap_a) a_ff <= reg_ok(src_ff, vld_ff) ? rf_rdata : '0;
      if (cmd.cap_b) b_ff <= use_imm_ff ? imm_ff : (reg_ok(sec_ff, vld_ff) ? rf_rdata : '0);
      if (cmd.cap_d) d_ff <= reg_ok(dst_ff, vld_ff) ? rf_rdata : '0;
      if (cmd.cap_lo) lo_ff <= mem_rdata;
      if (cmd.cap_hi) hi_ff <= mem_rdata;
      if (cmd.div_start) begin
         quo_ff  <= a_mag;
         rem_ff  <= '0;
         dvs_ff  <= b_mag;
         qneg_ff <= a_ff[15] ^ b_ff[15];
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_dif[17] ? rem_sh[16:0] : rem_dif[16:0];
         quo_ff  <= {quo_ff[15:0], !rem_dif[17]};
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      if (cmd.commit) begin
         rsp_data_ff <= {n_in, c_in, z_in, outok, outv, tadj[16:2] & {15{taken}}, taken, stat};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         z_ff         <= 1'b0;
         c_ff         <= 1'b0;
         n_ff         <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_we) clr_ff <= clr_ff + AW'(1);
         if (cmd.commit) begin
            z_ff <= z_in;
            c_ff <= c_in;
            n_ff <= n_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rf_we) vld_ff[dst_ff[IW-1:0]] <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

[sv/risc16_execute_unit.sv]
// Executes one decoded 16-bit instruction per request word and returns one
// response word with status, jump, out value and flags. After reset the data
// memory is zeroed by a clearing pass over all MEM_BYTES bytes (65536 by
// default), during which no request is taken. Register operations make three
// register file reads through its single read port; loads and stores also
// use the byte-wide memory port, one byte per access, and div runs the
// 17-step bit-serial divider. One instruction is in flight at a time; a
// finished response waits in the output register while the next request is
// accepted.
module risc16_execute_unit #(
   parameter int MEM_BYTES = 65536,
   parameter int REG_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[4:0], dest_reg[9:5], src_reg[14:10], second_reg[19:15],
   // immediate[35:20], in_value[51:36], zero fill
   input  logic [55:0] req_tdata,
   // use_immediate[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], jump_taken[2], jump_target[17:3], out_value[33:18],
   // out_valid[34], flag_z[35], flag_c[36], flag_n[37], zero fill
   output logic [39:0] rsp_tdata
);

   r16x_pkg::cmd_type cmd;
   r16x_pkg::sts_type sts;

   r16x_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .sts(sts), .cmd(cmd)
   );

   r16x_dpath #(.MEM_BYTES(MEM_BYTES), .REG_COUNT(REG_COUNT)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an instruction is in flight");

   a_out_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34] |-> rsp_tdata[2:0] == 3'd0)
      else $error("out response carries status or jump");

   a_jump_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] == r16x_pkg::STAT_OK)
      else $error("taken jump with nonzero status");

   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_tvalid || rsp_tready)
      else $error("response overwritten before taken");

endmodule

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 500;

   typedef struct packed {
      logic        n;
      logic        c;
      logic        z;
      logic        out_valid;
      logic [15:0] out_value;
      logic [14:0] target;
      logic        taken;
      logic [1:0]  status;
   } rsp_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   logic signed [15:0] regs [0:31];
   logic [7:0]         ram [0:65535];
   logic               zf, cf, nf;

   rsp_word_type expected_rsp [$];
   int        errors;
   int        idle_cycles;
   int        send_idle_pct;
   int        recv_idle_pct;

   risc16_execute_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int reg_value(logic [4:0] idx);
      return (idx == 0) ? 0 : int'(regs[idx]);
   endfunction

   function automatic void set_zn(int v);
      zf = (v == 0);
      nf = (v < 0);
   endfunction

   function automatic void write_reg(logic [4:0] idx, int v);
      logic [15:0] t;
      int          w;
      t = v[15:0];
      w = int'($signed(t));
      set_zn(w);
      if (idx != 0) regs[idx] = t;
   endfunction

   function automatic int sext8(int v);
      logic [7:0] t;
      t = v[7:0];
      return int'($signed(t));
   endfunction

   function automatic rsp_word_type execute(logic [4:0] op, logic [4:0] d, logic [4:0] s,
                                            logic use_imm, logic [4:0] s2,
                                            logic [15:0] imm, logic [15:0] inv);
      rsp_word_type r;
      int          a, b, res, ad, n, tgt;
      logic [15:0] u;
      logic        go;
      r = '0;
      a = reg_value(s);
      b = use_imm ? int'($signed(imm)) : reg_value(s2);
      u = a[15:0];
      case (op)
         r16x_pkg::OP_ADD, r16x_pkg::OP_SUB: begin
            res = (op == r16x_pkg::OP_ADD) ? a + b : a - b;
            if (res > 32767 || res < -32768) r.status = r16x_pkg::STAT_OVF;
            write_reg(d, res);
         end
         r16x_pkg::OP_MUL: write_reg(d, sext8(a) * sext8(b));
         r16x_pkg::OP_DIV: begin
            if (b == 0) r.status = r16x_pkg::STAT_DIVZ;
            else write_reg(d, a / b);
         end
         r16x_pkg::OP_AND: write_reg(d, a & b);
         r16x_pkg::OP_OR:  write_reg(d, a | b);
         r16x_pkg::OP_XOR: write_reg(d, a ^ b);
         r16x_pkg::OP_SHL: begin
            if (b == 0) begin
               set_zn(reg_value(d));
            end else if (b > 16 || b < -16) begin
               cf = 1'b0;
               write_reg(d, 0);
            end else if (b > 0) begin
               cf = u[16 - b];
               write_reg(d, int'({16'd0, u << b}));
            end else begin
               n = -b;
               cf = u[n - 1];
               write_reg(d, int'({16'd0, u >> n}));
            end
         end
         r16x_pkg::OP_STB, r16x_pkg::OP_STW: begin
            ad = reg_value(d) + b;
            if (ad < 0 || ad > 65535 || (op == r16x_pkg::OP_STW && ad + 1 > 65535)) begin
               r.status = r16x_pkg::STAT_ADDR;
            end else begin
               ram[ad] = u[7:0];
               if (op == r16x_pkg::OP_STW) begin
                  ram[ad + 1] = u[15:8];
                  set_zn(sext8(int'(u[15:8])));
               end else begin
                  set_zn(sext8(int'(u[7:0])));
               end
            end
         end
         r16x_pkg::OP_LDB, r16x_pkg::OP_LDW: begin
            ad = a + b;
            if (ad < 0 || ad > 65535 || (op == r16x_pkg::OP_LDW && ad + 1 > 65535))
               r.status = r16x_pkg::STAT_ADDR;
            else if (op == r16x_pkg::OP_LDB)
               write_reg(d, sext8(int'(ram[ad])));
            else
               write_reg(d, int'($signed({ram[ad + 1], ram[ad]})));
         end
         r16x_pkg::OP_JMP, r16x_pkg::OP_JZS, r16x_pkg::OP_JZC, r16x_pkg::OP_JCS,
         r16x_pkg::OP_JCC, r16x_pkg::OP_JNS, r16x_pkg::OP_JNC: begin
            case (op)
               r16x_pkg::OP_JZS: go = zf;
               r16x_pkg::OP_JZC: go = !zf;
               r16x_pkg::OP_JCS: go = cf;
               r16x_pkg::OP_JCC: go = !cf;
               r16x_pkg::OP_JNS: go = nf;
               r16x_pkg::OP_JNC: go = !nf;
               default: go = 1'b1;
            endcase
            if (go) begin
               tgt = (use_imm ? int'($signed(imm)) : reg_value(d)) / 4;
               r.taken = 1'b1;
               r.target = tgt[14:0];
            end
         end
         r16x_pkg::OP_IN: write_reg(d, int'($signed(inv)));
         r16x_pkg::OP_OUT: begin
            tgt = reg_value(d);
            r.out_value = tgt[15:0];
            r.out_valid = 1'b1;
         end
         default: ;
      endcase
      r.z = zf;
      r.c = cf;
      r.n = nf;
      return r;
   endfunction

   task automatic send_instr(logic [4:0] op, logic [4:0] d, logic [4:0] s, logic use_imm,
                             logic [4:0] s2, logic [15:0] imm, logic [15:0] inv);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      expected_rsp.push_back(execute(op, d, s, use_imm, s2, imm, inv));
      req_tvalid <= 1'b1;
      req_tuser  <= use_imm;
      req_tdata  <= {4'd0, inv, imm, s2, s, d, op};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[37:0];
         if (expected_rsp.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("jump_taken", want.taken, got.taken);
            compare_field("jump_target", want.target, got.target);
            compare_field("out_value", want.out_value, got.out_value);
            compare_field("out_valid", want.out_valid, got.out_valid);
            compare_field("flag_z", want.z, got.z);
            compare_field("flag_c", want.c, got.c);
            compare_field("flag_n", want.n, got.n);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset)
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("risc16_execute_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_arith_edges();
      send_instr(r16x_pkg::OP_IN, 5'd1, 5'd0, 1'b0, 5'd0, 16'd0, 16'h7FFF);
      send_instr(r16x_pkg::OP_IN, 5'd2, 5'd0, 1'b0, 5'd0, 16'd0, 16'h8000);
      send_instr(r16x_pkg::OP_ADD, 5'd3, 5'd1, 1'b1, 5'd0, 16'd1, 16'd0);
      send_instr(r16x_pkg::OP_SUB, 5'd3, 5'd2, 1'b1, 5'd0, 16'd1, 16'd0);
      send_instr(r16x_pkg::OP_MUL, 5'd4, 5'd1, 1'b0, 5'd2, 16'd0, 16'd0);
      send_instr(r16x_pkg::OP_DIV, 5'd5, 5'd1, 1'b1, 5'd0, 16'd0, 16'd0);
      send_instr(r16x_pkg::OP_DIV, 5'd6, 5'd2, 1'b1, 5'd0, 16'hFFFF, 16'd0);
      send_instr(r16x_pkg::OP_AND, 5'd7, 5'd1, 1'b0, 5'd2, 16'd0, 16'd0);
      send_instr(r16x_pkg::OP_OR,  5'd7, 5'd1, 1'b0, 5'd2, 16'd0, 16'd0);
      send_instr(r16x_pkg::OP_XOR, 5'd0, 5'd1, 1'b1, 5'd0, 16'h7FFF, 16'd0);
      send_instr(r16x_pkg::OP_SHL, 5'd8, 5'd2, 1'b1, 5'd0, 16'd1, 16'd0);
      send_instr(r16x_pkg::OP_SHL, 5'd8, 5'd2, 1'b1, 5'd0, 16'hFFF0, 16'd0);
      send_instr(r16x_pkg::OP_SHL, 5'd8, 5'd1, 1'b1, 5'd0, 16'd17, 16'd0);
      send_instr(r16x_pkg::OP_SHL, 5'd1, 5'd1, 1'b1, 5'd0, 16'd0, 16'd0);
   endtask

   task automatic test_memory_edges();
      send_instr(r16x_pkg::OP_STW, 5'd0, 5'd2, 1'b1, 5'd0, 16'hFFFF, 16'd0);
      send_instr(r16x_pkg::OP_STW, 5'd0, 5'd1, 1'b1, 5'd0, 16'hFFFE, 16'd0);
      send_instr(r16x_pkg::OP_LDW, 5'd9, 5'd0, 1'b1, 5'd0, 16'hFFFE, 16'd0);
      send_instr(r16x_pkg::OP_STB, 5'd2, 5'd1, 1'b1, 5'd0, 16'd0, 16'd0);
      send_instr(r16x_pkg::OP_LDB, 5'd9, 5'd0, 1'b1, 5'd0, 16'hFFFF, 16'd0);
      send_instr(r16x_pkg::OP_LDB, 5'd9, 5'd0, 1'b1, 5'd0, 16'd0, 16'd0);
   endtask

   task automatic test_jumps();
      send_instr(r16x_pkg::OP_JMP, 5'd0, 5'd0, 1'b1, 5'd0, 16'h8000, 16'd0);
      send_instr(r16x_pkg::OP_JZS, 5'd2, 5'd0, 1'b0, 5'd0, 16'd0, 16'd0);
      send_instr(r16x_pkg::OP_JZC, 5'd1, 5'd0, 1'b0, 5'd0, 16'd0, 16'd0);
      send_instr(r16x_pkg::OP_JCS, 5'd0, 5'd0, 1'b1, 5'd0, 16'hFFFD, 16'd0);
      send_instr(r16x_pkg::OP_JCC, 5'd0, 5'd0, 1'b1, 5'd0, 16'h7FFF, 16'd0);
      send_instr(r16x_pkg::OP_JNS, 5'd0, 5'd0, 1'b1, 5'd0, 16'd5, 16'd0);
      send_instr(r16x_pkg::OP_JNC, 5'd0, 5'd0, 1'b1, 5'd0, 16'd5, 16'd0);
      send_instr(r16x_pkg::OP_OUT, 5'd2, 5'd0, 1'b0, 5'd0, 16'd0, 16'd0);
      send_instr(5'd31, 5'd31, 5'd31, 1'b1, 5'd31, 16'hFFFF, 16'hFFFF);
   endtask

   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_random_traffic(int count);
      logic [4:0]  op, d, s, s2;
      logic        use_imm;
      logic [15:0] imm, inv;
      int          want_addr;
      repeat (count) begin
         op  = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(21, 31))
                                            : 5'($urandom_range(0, 20));
         d   = pick_reg();
         s   = pick_reg();
         s2  = pick_reg();
         use_imm = 1'($urandom_range(0, 1));
         imm = pick_value();
         inv = pick_value();
         if (op == r16x_pkg::OP_SHL && $urandom_range(0, 3) != 0)
            imm = 16'($urandom_range(0, 36)) - 16'd18;
         if (op >= r16x_pkg::OP_STB && op <= r16x_pkg::OP_LDW && $urandom_range(0, 4) != 0) begin
            want_addr = ($urandom_range(0, 3) == 0) ? $urandom_range(65528, 65535)
                                                    : $urandom_range(0, 31);
            use_imm = 1'b1;
            imm = 16'(want_addr - reg_value((op <= r16x_pkg::OP_STW) ? d : s));
         end
         send_instr(op, d, s, use_imm, s2, imm, inv);
      end
   endtask

   initial begin
      errors = 0;
      idle_cycles = 0;
      send_idle_pct = 36;
      recv_idle_pct = 45;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      for (int i = 0; i < 32; i++) regs[i] = '0;
      for (int i = 0; i < 65536; i++) ram[i] = '0;
      zf = 1'b0;
      cf = 1'b0;
      nf = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_arith_edges();
      test_memory_edges();
      test_jumps();
      test_random_traffic(RANDOM_ITEMS);
      send_idle_pct = 45;
      recv_idle_pct = 36;
      test_random_traffic(RANDOM_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(RANDOM_ITEMS);
      req_tvalid <= 1'b0;
      wait (expected_rsp.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("risc16_execute_unit test passed");
      else
         $display("risc16_execute_unit test failed");
      $finish;
   end
endmodule

[files.f]
sv/r16x_pkg.sv
sv/r16x_ram.sv
sv/r16x_ctrl.sv
sv/r16x_dpath.sv
sv/risc16_execute_unit.sv
tb/tb.sv
